/* rtl/core/ntlt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntlt_pkg
// Shared types and constants for the name-to-task lookup table.
// ----------------------------------------------------------------------------
package ntlt_pkg;

   localparam int ENTRIES_DEF    = 64;
   localparam int NAME_BYTES_DEF = 32;
   localparam int WORD_W         = 64;
   localparam int NAME_WORDS     = 4;
   localparam int RAW_NAME_W     = NAME_WORDS * WORD_W;
   localparam int TASK_W         = 8;
   localparam int FOUND_W        = 9;

   localparam logic [FOUND_W-1:0] TASK_NONE = '1;

   typedef enum logic {
      OP_REGISTER = 1'b0,
      OP_LOOKUP   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

/* rtl/core/ntlt_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntlt_norm
// Name cleanup: cuts the name at its first zero byte and drops bytes past
// NAME_BYTES.
// ----------------------------------------------------------------------------
module ntlt_norm #(
   parameter int NAME_BYTES = ntlt_pkg::NAME_BYTES_DEF
) (
   input  logic [ntlt_pkg::RAW_NAME_W-1:0] raw_name,
   output logic [NAME_BYTES*8-1:0]         clean_name
);

   always_comb begin
      logic       ended;
      logic [7:0] cur;
      ended      = 1'b0;
      clean_name = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         cur   = raw_name[8*b +: 8];
         ended = ended | (cur == 8'd0);
         clean_name[8*b +: 8] = ended ? 8'd0 : cur;
      end
   end

endmodule

/* rtl/core/name_to_task_lookup_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_to_task_lookup_table_unit
// Name registry: register a name for a task, or look a name up.
// ----------------------------------------------------------------------------
// A register request (tuser = 0) stores the cleaned name and the requester in
// the next free entry and answers ok, or full once ENTRIES names are held. A
// look-up request (tuser = 1) walks the used entries through the single read
// port of the name memory, one entry per cycle, and answers with the owner of
// the first equal name or with not found and task -1; a match ends the walk
// early. One request is worked on at a time; the next one is taken as soon
// as the engine is idle, even while the last answer waits.
// ----------------------------------------------------------------------------
module name_to_task_lookup_table_unit #(
   parameter int ENTRIES    = ntlt_pkg::ENTRIES_DEF,
   parameter int NAME_BYTES = ntlt_pkg::NAME_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // requester[7:0], name_word0[71:8], name_word1[135:72],
   // name_word2[199:136], name_word3[263:200]
   input  logic [263:0] req_tdata,
   // opcode[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reply_to[7:0], found_task[16:8], zero[23:17]
   output logic [23:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int NAME_W = NAME_BYTES * 8;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int TW     = ntlt_pkg::TASK_W;
   localparam int FW     = ntlt_pkg::FOUND_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [NAME_W-1:0] name_mem  [ENTRIES];
   logic [TW-1:0]     owner_mem [ENTRIES];

   logic [NAME_W-1:0] clean_name;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [TW-1:0]     requester_ff, requester_in;
   logic              lookup_ff, lookup_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              cmp_vld_ff, cmp_vld_in;
   ntlt_pkg::status_type res_status_ff, res_status_in;
   logic [FW-1:0]     res_task_ff, res_task_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [NAME_W-1:0] name_rd_ff;
   logic [TW-1:0]     owner_rd_ff;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [TW-1:0]     rsp_reply_ff, rsp_reply_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [FW-1:0]     rsp_task_ff, rsp_task_in;
   logic              out_free;

   ntlt_norm #(
      .NAME_BYTES (NAME_BYTES)
   ) u_norm (
      .raw_name   (req_tdata[263:8]),
      .clean_name (clean_name)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      requester_in  = requester_ff;
      lookup_in     = lookup_ff;
      used_in       = used_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_reply_in  = rsp_reply_ff;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in       = clean_name;
               requester_in = req_tdata[7:0];
               lookup_in    = (req_tuser[0] == ntlt_pkg::OP_LOOKUP);
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            res_task_in = ntlt_pkg::TASK_NONE;
            issue_in    = '0;
            if (lookup_ff) begin
               state_in = S_SCAN;
            end else begin
               if (used_ff < CNT_W'(ENTRIES)) begin
                  wr_en         = 1'b1;
                  used_in       = used_ff + CNT_W'(1);
                  res_status_in = ntlt_pkg::ST_OK;
               end else begin
                  res_status_in = ntlt_pkg::ST_FULL;
               end
               state_in = S_RESULT;
            end
         end
         S_SCAN: begin
            // read one entry per cycle; compare works on the registered read in the next cycle
            if (issue_ff < used_ff) begin
               rd_en      = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff && (name_rd_ff == key_ff)) begin
               res_status_in = ntlt_pkg::ST_FOUND;
               res_task_in   = {1'b0, owner_rd_ff};
               cmp_vld_in    = 1'b0;
               state_in      = S_RESULT;
            end else if (!cmp_vld_ff && (issue_ff >= used_ff)) begin
               res_status_in = ntlt_pkg::ST_NOT_FOUND;
               res_task_in   = ntlt_pkg::TASK_NONE;
               state_in      = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_reply_in  = requester_ff;
               rsp_status_in = res_status_ff;
               rsp_task_in   = res_task_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         issue_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      requester_ff  <= requester_in;
      lookup_ff     <= lookup_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      rsp_reply_ff  <= rsp_reply_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
   end

   // name and owner memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[used_ff[IDX_W-1:0]]  <= key_ff;
         owner_mem[used_ff[IDX_W-1:0]] <= requester_ff;
      end
      if (rd_en) begin
         name_rd_ff  <= name_mem[rd_addr];
         owner_rd_ff <= owner_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_task_ff, rsp_reply_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register and look-up requests into the name table, mirrors the table
// in a local model, and compares every response field against it. A short
// directed table comes first, then a long random run that fills the table and
// keeps looking names up, with random gaps on both sides and one long
// response hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ENTRIES_N    = ntlt_pkg::ENTRIES_DEF;
   localparam int NAME_BYTES_N = ntlt_pkg::NAME_BYTES_DEF;
   localparam int FW           = ntlt_pkg::FOUND_W;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [7:0]           reply_to;
      ntlt_pkg::status_type status;
      logic [FW-1:0]        found_task;
   } answer_type;

   typedef struct {
      ntlt_pkg::opcode_type op;
      logic [7:0]           who;
      logic [255:0]         name;
      bit                   typed;
      ntlt_pkg::status_type status;
      logic [FW-1:0]        owner;
   } probe_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [263:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   // typed expectation carried alongside the request being offered
   bit                   row_typed;
   ntlt_pkg::status_type row_status;
   logic [FW-1:0]        row_owner;

   // local copy of the table
   logic [255:0] name_table [ENTRIES_N];
   logic [7:0]   owner_table [ENTRIES_N];
   int           fill_count;

   answer_type pending_answers [$];
   int         failures;
   bit         steady;
   bit         hold_off;

   name_to_task_lookup_table_unit #(
      .ENTRIES    (ENTRIES_N),
      .NAME_BYTES (NAME_BYTES_N)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // cut at the first zero byte; everything after counts as zero
   function automatic logic [255:0] clean_name(logic [255:0] raw);
      logic [255:0] c;
      bit           ended;
      c     = '0;
      ended = 1'b0;
      for (int k = 0; k < 32; k++) begin
         if (k >= NAME_BYTES_N || raw[8*k +: 8] == 8'h00) ended = 1'b1;
         if (!ended) c[8*k +: 8] = raw[8*k +: 8];
      end
      return c;
   endfunction

   function automatic answer_type predict_answer(ntlt_pkg::opcode_type op,
                                                 logic [7:0] who,
                                                 logic [255:0] raw);
      logic [255:0] key;
      answer_type   ans;
      key            = clean_name(raw);
      ans.reply_to   = who;
      ans.found_task = ntlt_pkg::TASK_NONE;
      if (op == ntlt_pkg::OP_REGISTER) begin
         if (fill_count < ENTRIES_N) begin
            name_table[fill_count]  = key;
            owner_table[fill_count] = who;
            fill_count++;
            ans.status = ntlt_pkg::ST_OK;
         end else begin
            ans.status = ntlt_pkg::ST_FULL;
         end
      end else begin
         ans.status = ntlt_pkg::ST_NOT_FOUND;
         for (int i = 0; i < fill_count; i++) begin
            if (name_table[i] == key) begin
               ans.status     = ntlt_pkg::ST_FOUND;
               ans.found_task = {1'b0, owner_table[i]};
               break;
            end
         end
      end
      return ans;
   endfunction

   // random bytes after the terminator; the name stays the same once cleaned
   function automatic logic [255:0] dress_name(logic [255:0] n);
      bit past;
      past = 1'b0;
      for (int k = 0; k < 32; k++) begin
         if (past) n[8*k +: 8] = 8'($urandom_range(0, 255));
         else if (n[8*k +: 8] == 8'h00) past = 1'b1;
      end
      return n;
   endfunction

   function automatic logic [255:0] fresh_name();
      logic [255:0] n;
      int           len;
      int           r;
      bit           junk;
      r    = $urandom_range(0, 9);
      len  = (r == 0) ? 0 : (r == 1) ? 32 : (r == 2) ? 31 : $urandom_range(1, 12);
      junk = $urandom_range(0, 1);
      n    = '0;
      for (int k = 0; k < 32; k++) begin
         if (k < len) n[8*k +: 8] = 8'($urandom_range(1, 255));
         else if (k > len && junk) n[8*k +: 8] = 8'($urandom_range(0, 255));
      end
      return n;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic probe_type make_row(ntlt_pkg::opcode_type op, logic [7:0] who,
                                          logic [255:0] name, bit typed,
                                          ntlt_pkg::status_type st,
                                          logic [FW-1:0] owner);
      probe_type p;
      p.op     = op;
      p.who    = who;
      p.name   = name;
      p.typed  = typed;
      p.status = st;
      p.owner  = owner;
      return p;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer(probe_type p, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= p.op;
      req_tdata  <= {p.name, p.who};
      row_typed  <= p.typed;
      row_status <= p.status;
      row_owner  <= p.owner;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // request accepted: predict its answer
   always @(posedge clock) begin
      answer_type want;
      if (!reset && req_tvalid && req_tready) begin
         want = predict_answer(ntlt_pkg::opcode_type'(req_tuser), req_tdata[7:0],
                               req_tdata[263:8]);
         if (row_typed) want = '{req_tdata[7:0], row_status, row_owner};
         pending_answers.push_back(want);
      end
   end

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], ntlt_pkg::status_type'(rsp_tuser), rsp_tdata[16:8]};
         if (pending_answers.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: to=%0d st=%s task=%h",
                        got.reply_to, got.status.name(), got.found_task);
         end else begin
            want = pending_answers.pop_front();
            if (got.reply_to !== want.reply_to || got.status !== want.status ||
                got.found_task !== want.found_task) begin
               failures++;
               if (failures <= 10)
                  $display(
                     "mismatch: expected to=%0d st=%s task=%h, got to=%0d st=%s task=%h",
                     want.reply_to, want.status.name(), want.found_task,
                     got.reply_to, got.status.name(), got.found_task);
            end
         end
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int r;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (steady || r < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat ((r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39))
               @(negedge clock);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      probe_type    directed_rows [$];
      probe_type    p;
      logic [255:0] abc;
      int           r;
      int           reg_share;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ntlt_pkg::OP_REGISTER;
      row_typed  = 1'b0;
      row_status = ntlt_pkg::ST_OK;
      row_owner  = ntlt_pkg::TASK_NONE;
      fill_count = 0;
      failures   = 0;
      steady     = 1'b0;
      hold_off   = 1'b0;

      abc = 256'h636261;
      // empty table, then extremes of the name
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h00, '0, 1,
                                       ntlt_pkg::ST_NOT_FOUND, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'hFF, '1, 1,
                                       ntlt_pkg::ST_NOT_FOUND, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_REGISTER, 8'hFF, '1, 1,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_REGISTER, 8'h00, '0, 1,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h12, '1, 1,
                                       ntlt_pkg::ST_FOUND, 9'h0FF));
      // zero first byte with junk behind it equals the empty name
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h34,
                                       {{31{8'hFF}}, 8'h00}, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_REGISTER, 8'h5A,
                                       {{28{8'hA5}}, 8'h00, 24'h636261}, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h01, abc, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      // duplicate: the first owner keeps answering
      directed_rows.push_back(make_row(ntlt_pkg::OP_REGISTER, 8'h33, abc, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h02,
                                       {{28{8'h5C}}, 8'h00, 24'h636261}, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h03, 256'h646261, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h04, 256'h64636261, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_REGISTER, 8'h80,
                                       {{23{8'hC3}}, 8'h00, 64'h0102030405060708}, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h7F,
                                       256'h0102030405060708, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'hAA,
                                       {8'h01, {31{8'hFF}}}, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));
      directed_rows.push_back(make_row(ntlt_pkg::OP_LOOKUP, 8'h55,
                                       {8'h00, {31{8'hFF}}}, 0,
                                       ntlt_pkg::ST_OK, ntlt_pkg::TASK_NONE));

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) offer(directed_rows[i], gap_len());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 400 && n < 500);
         if (n == 250) hold_off = 1'b1;
         p.typed   = 1'b0;
         p.status  = ntlt_pkg::ST_OK;
         p.owner   = ntlt_pkg::TASK_NONE;
         p.who     = 8'($urandom_range(0, 255));
         // register-heavy at first so the table fills early
         reg_share = (n < 150) ? 50 : 30;
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < reg_share) begin
            p.op = ntlt_pkg::OP_REGISTER;
            if (r < 25 && fill_count > 0)
               p.name = dress_name(name_table[$urandom_range(0, fill_count - 1)]);
            else
               p.name = fresh_name();
         end else begin
            p.op = ntlt_pkg::OP_LOOKUP;
            if (r < 80 && fill_count > 0) begin
               p.name = name_table[$urandom_range(0, fill_count - 1)];
               if (r >= 60)
                  p.name[8*$urandom_range(0, 31) +: 8] ^= 8'(1 << $urandom_range(0, 7));
               if ($urandom_range(0, 1)) p.name = dress_name(p.name);
            end else begin
               p.name = fresh_name();
            end
         end
         offer(p, gap_len());
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/ntlt_pkg.sv
rtl/core/ntlt_norm.sv
rtl/core/name_to_task_lookup_table_unit.sv
sim/testbench.sv
